// ===== hdl/olrr_pkg.sv =====
// ----------------------------------------------------------------------------
// olrr_pkg
// shared types and codes for the ordered list with round-robin cursor
// ----------------------------------------------------------------------------
package olrr_pkg;

    // operation codes carried in the action field
    typedef enum logic [2:0] {
        ACT_APPEND   = 3'd0,
        ACT_REMOVE   = 3'd1,
        ACT_POP      = 3'd2,
        ACT_READ     = 3'd3,
        ACT_ADV_WRAP = 3'd4,
        ACT_ADVANCE  = 3'd5
    } action_t;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        logic [2:0]  action;
        logic [31:0] value;
        logic [3:0]  index;
    } req_item_t;

    typedef struct packed {
        logic [31:0] data;
        logic [1:0]  status;
        logic [4:0]  entry_count;
        logic        cursor_valid;
        logic [31:0] current_value;
    } rsp_item_t;

endpackage

// ===== hdl/olrr_ram.sv =====
// ----------------------------------------------------------------------------
// olrr_ram
// handle storage, one write port and one read port with registered read data
// ----------------------------------------------------------------------------
module olrr_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read data holds while no read is issued
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/ordered_list_round_robin_cursor.sv =====
// ----------------------------------------------------------------------------
// ordered_list_round_robin_cursor
// bounded ordered list of handles with a round-robin cursor
// ----------------------------------------------------------------------------
// usage:
//   req channel carries one item (action, value, index); rsp channel returns
//   exactly one item per request (data, status, entry_count, cursor_valid,
//   current_value). both channels use valid/stall; an item moves on a rising
//   edge with valid high and stall low.
//   the list sits in a single-port-write, single-port-read memory; a small
//   sequencer drives that port over and over. removal and pop shift the later
//   entries up one place per cycle through the memory port.
//   an accepted item passes through execute, cursor read and capture states;
//   read adds a data fetch after execute; remove adds one shift step per
//   later entry and a drop step; pop adds a pop step, one shift step per
//   remaining entry and a drop step; an item that fails a check adds none.
//   one item is worked on at a time: req_stall is high from acceptance until
//   the result is loaded into the rsp register, and the next item is taken
//   in the cycle after that; no item starts before the last one is done.
//   a finished result waits in the rsp register while the next item is taken
//   in; if the rsp register is still full and stalled when the next result is
//   ready, the sequencer holds until it drains.
//   reset empties the list and clears the cursor; entries need no clearing
//   since only values at positions below the count are ever used.
// ----------------------------------------------------------------------------
module ordered_list_round_robin_cursor #(
    parameter int DEPTH        = 16,
    parameter int HANDLE_WIDTH = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_stall,
    input  olrr_pkg::req_item_t  req,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output olrr_pkg::rsp_item_t  rsp
);

    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int CMP_W   = (CNT_W > 4) ? CNT_W : 4;
    localparam int STORE_W = (HANDLE_WIDTH < 32) ? HANDLE_WIDTH : 32;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_POP,
        S_DATA,
        S_SHIFT,
        S_DROP,
        S_READ,
        S_CAP
    } state_t;

    state_t              state_reg, state_next;

    // latched request
    olrr_pkg::action_t   act_reg, act_next;
    logic [STORE_W-1:0]  val_reg, val_next;
    logic [3:0]          idx_reg, idx_next;

    // list state
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [ADDR_W-1:0]   cur_reg, cur_next;
    logic                cur_ok_reg, cur_ok_next;

    // shift walk
    logic [ADDR_W-1:0]   pos_reg, pos_next;
    logic [ADDR_W-1:0]   ptr_reg, ptr_next;

    // result being built
    logic [31:0]         data_reg, data_next;
    olrr_pkg::status_t   status_reg, status_next;

    // rsp register
    logic                rsp_valid_reg, rsp_valid_next;
    olrr_pkg::rsp_item_t rsp_reg, rsp_next;

    // memory port
    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr;
    logic [STORE_W-1:0]  mem_wdata;
    logic                mem_re;
    logic [ADDR_W-1:0]   mem_raddr;
    logic [STORE_W-1:0]  mem_rdata;

    logic                idx_in_range;
    logic                list_full;
    logic                list_empty;
    logic [CNT_W-1:0]    cur_plus1;

    olrr_ram #(
        .DEPTH (DEPTH),
        .WIDTH (STORE_W)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign idx_in_range = (CMP_W'(idx_reg) < CMP_W'(count_reg));
    assign list_full    = (count_reg == CNT_W'(DEPTH));
    assign list_empty   = (count_reg == '0);
    assign cur_plus1    = CNT_W'(cur_reg) + CNT_W'(1);

    always_comb
    begin
        state_next     = state_reg;
        act_next       = act_reg;
        val_next       = val_reg;
        idx_next       = idx_reg;
        count_next     = count_reg;
        cur_next       = cur_reg;
        cur_ok_next    = cur_ok_reg;
        pos_next       = pos_reg;
        ptr_next       = ptr_reg;
        data_next      = data_reg;
        status_next    = status_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        mem_we         = 1'b0;
        mem_waddr      = '0;
        mem_wdata      = '0;
        mem_re         = 1'b0;
        mem_raddr      = '0;

        // rsp register drains when taken
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    act_next    = olrr_pkg::action_t'(req.action);
                    val_next    = STORE_W'(req.value);
                    idx_next    = req.index;
                    data_next   = '0;
                    status_next = olrr_pkg::ST_OK;
                    state_next  = S_EXEC;
                end
            end

            S_EXEC:
            begin
                state_next = S_READ;
                case (act_reg)
                    olrr_pkg::ACT_APPEND:
                    begin
                        if (list_full)
                        begin
                            status_next = olrr_pkg::ST_FULL;
                        end
                        else
                        begin
                            mem_we     = 1'b1;
                            mem_waddr  = ADDR_W'(count_reg);
                            mem_wdata  = val_reg;
                            count_next = count_reg + CNT_W'(1);
                            if (list_empty)
                            begin
                                cur_ok_next = 1'b1;
                                cur_next    = '0;
                            end
                        end
                    end
                    olrr_pkg::ACT_REMOVE:
                    begin
                        if (!idx_in_range)
                        begin
                            status_next = olrr_pkg::ST_RANGE;
                        end
                        else
                        begin
                            pos_next = ADDR_W'(idx_reg);
                            ptr_next = ADDR_W'(idx_reg);
                            if (CNT_W'(idx_reg) + CNT_W'(1) < count_reg)
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = ADDR_W'(idx_reg) + ADDR_W'(1);
                                state_next = S_SHIFT;
                            end
                            else
                            begin
                                state_next = S_DROP;
                            end
                        end
                    end
                    olrr_pkg::ACT_POP:
                    begin
                        if (list_empty)
                        begin
                            status_next = olrr_pkg::ST_RANGE;
                        end
                        else
                        begin
                            mem_re     = 1'b1;
                            mem_raddr  = '0;
                            pos_next   = '0;
                            state_next = S_POP;
                        end
                    end
                    olrr_pkg::ACT_READ:
                    begin
                        if (!idx_in_range)
                        begin
                            status_next = olrr_pkg::ST_RANGE;
                        end
                        else
                        begin
                            mem_re     = 1'b1;
                            mem_raddr  = ADDR_W'(idx_reg);
                            state_next = S_DATA;
                        end
                    end
                    olrr_pkg::ACT_ADV_WRAP:
                    begin
                        if (list_empty)
                        begin
                            status_next = olrr_pkg::ST_RANGE;
                        end
                        else if (cur_ok_reg && (cur_plus1 < count_reg))
                        begin
                            cur_next = cur_reg + ADDR_W'(1);
                        end
                        else
                        begin
                            cur_ok_next = 1'b1;
                            cur_next    = '0;
                        end
                    end
                    olrr_pkg::ACT_ADVANCE:
                    begin
                        if (list_empty)
                        begin
                            status_next = olrr_pkg::ST_RANGE;
                        end
                        else if (cur_ok_reg)
                        begin
                            if (cur_plus1 < count_reg)
                            begin
                                cur_next = cur_reg + ADDR_W'(1);
                            end
                            else
                            begin
                                cur_ok_next = 1'b0;
                                cur_next    = '0;
                            end
                        end
                    end
                    default:
                    begin
                        // unused codes leave the list alone
                    end
                endcase
            end

            S_POP:
            begin
                data_next = 32'(mem_rdata);
                ptr_next  = '0;
                if (count_reg > CNT_W'(1))
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = ADDR_W'(1);
                    state_next = S_SHIFT;
                end
                else
                begin
                    state_next = S_DROP;
                end
            end

            S_DATA:
            begin
                data_next  = 32'(mem_rdata);
                state_next = S_READ;
            end

            S_SHIFT:
            begin
                // move entry ptr+1 into ptr, fetch the next one behind it
                mem_we    = 1'b1;
                mem_waddr = ptr_reg;
                mem_wdata = mem_rdata;
                ptr_next  = ptr_reg + ADDR_W'(1);
                if (CNT_W'(ptr_reg) + CNT_W'(2) < count_reg)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = ptr_reg + ADDR_W'(2);
                end
                else
                begin
                    state_next = S_DROP;
                end
            end

            S_DROP:
            begin
                if (count_reg == CNT_W'(1))
                begin
                    count_next  = '0;
                    cur_ok_next = 1'b0;
                    cur_next    = '0;
                end
                else
                begin
                    count_next = count_reg - CNT_W'(1);
                    // cursor follows its entry; a cursor on the removed entry steps back one, one at 0 stays at 0
                    if (cur_ok_reg && (cur_reg >= pos_reg) && (cur_reg != '0))
                    begin
                        cur_next = cur_reg - ADDR_W'(1);
                    end
                end
                state_next = S_READ;
            end

            S_READ:
            begin
                mem_re     = 1'b1;
                mem_raddr  = cur_reg;
                state_next = S_CAP;
            end

            S_CAP:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next        = 1'b1;
                    rsp_next.data         = data_reg;
                    rsp_next.status       = status_reg;
                    rsp_next.entry_count  = 5'(count_reg);
                    rsp_next.cursor_valid = cur_ok_reg;
                    rsp_next.current_value =
                        (cur_ok_reg && (CNT_W'(cur_reg) < count_reg)) ?
                        32'(mem_rdata) : 32'd0;
                    state_next            = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            act_reg       <= olrr_pkg::ACT_APPEND;
            val_reg       <= '0;
            idx_reg       <= '0;
            count_reg     <= '0;
            cur_reg       <= '0;
            cur_ok_reg    <= 1'b0;
            pos_reg       <= '0;
            ptr_reg       <= '0;
            data_reg      <= '0;
            status_reg    <= olrr_pkg::ST_OK;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            act_reg       <= act_next;
            val_reg       <= val_next;
            idx_reg       <= idx_next;
            count_reg     <= count_next;
            cur_reg       <= cur_next;
            cur_ok_reg    <= cur_ok_next;
            pos_reg       <= pos_next;
            ptr_reg       <= ptr_next;
            data_reg      <= data_next;
            status_reg    <= status_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_reg       <= rsp_next;
        end
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef SYNTHESIS
    // count never passes capacity
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count above capacity");

    // a valid cursor always names a live entry
    a_cursor_live: assert property (@(posedge clk) disable iff (!rst_n)
        cur_ok_reg |-> (CNT_W'(cur_reg) < count_reg))
        else $error("cursor points past the tail");

    // an accepted item keeps the input side closed on the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> req_stall)
        else $error("input reopened right after accepting an item");

    // a result waiting under stall is never overwritten
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp)))
        else $error("stalled result changed");
`endif

endmodule
